// ===== rtl/sskc_pkg.sv =====
// Shared types and constants for the structured sort key comparator.
`timescale 1ns / 1ps
`default_nettype none
package sskc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ORDER_EQUAL  = 2'd0;
    localparam logic [1:0] ORDER_AFTER  = 2'd1;
    localparam logic [1:0] ORDER_BEFORE = 2'd2;

    localparam logic [2:0] HDR_FLAGS    = 3'd0;
    localparam logic [2:0] HDR_COUNTS   = 3'd1;
    localparam logic [2:0] HDR_VALUE_LO = 3'd4;
    localparam logic [2:0] HDR_VALUE_HI = 3'd5;

    localparam int          FLAG_STRUCT_BIT = 6;
    localparam logic [5:0]  FLAG_VALUE_MASK = 6'h3F;
    localparam logic [8:0]  LEFT_NEG        = 9'h1FF;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       last;
    } pair_t;

    typedef struct packed {
        logic       done;
        logic [1:0] verdict;
    } decision_t;

endpackage
`default_nettype wire

// ===== rtl/sskc_front.sv =====
// Front end: accepts byte pairs into a short queue ahead of the compare engine.
`timescale 1ns / 1ps
`default_nettype none
module sskc_front
    import sskc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] first_key_byte,
    input  wire logic [7:0] second_key_byte,
    input  wire logic       last_pair,
    output logic            q_valid,
    input  wire logic       q_ready,
    output pair_t           q_item
);

    pair_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;
    pair_t                  in_item;

    assign in_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        in_item.first_byte  = first_key_byte;
        in_item.second_byte = second_key_byte;
        in_item.last        = last_pair;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sskc_back.sv =====
// Back end: key compare engine and result register.
`timescale 1ns / 1ps
`default_nettype none
module sskc_back
    import sskc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire pair_t      q_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      order,
    output logic            undecided
);

    logic [2:0]  header_position_reg, header_position_next;
    logic [6:0]  first_flags_reg, first_flags_next;
    logic [5:0]  second_flags_reg, second_flags_next;
    logic [8:0]  first_left_reg, first_left_next;
    logic [8:0]  second_left_reg, second_left_next;
    logic [13:0] first_hv_reg, first_hv_next;
    logic [13:0] second_hv_reg, second_hv_next;
    logic [7:0]  first_len_reg, first_len_next;
    logic [7:0]  second_len_reg, second_len_next;
    logic [7:0]  to_compare_reg, to_compare_next;
    phase_t      phase_reg, phase_next;
    logic        ready_reg, ready_next;
    logic [1:0]  verdict_reg, verdict_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  order_reg, order_next;
    logic        undecided_reg, undecided_next;

    logic        pop;
    logic [7:0]  a;
    logic [7:0]  b;
    decision_t   dec;
    logic [7:0]  dec_count;

    function automatic decision_t check_counts(
        input logic [8:0]  left_f,
        input logic [8:0]  left_s,
        input logic        structured,
        input logic [13:0] hv_f,
        input logic [13:0] hv_s,
        input logic [5:0]  fl_f,
        input logic [5:0]  fl_s
    );
        decision_t d;
        d.done    = 1'b1;
        d.verdict = ORDER_EQUAL;
        if (left_f == '0)
        begin
            if (left_s != '0)
            begin
                d.verdict = ORDER_BEFORE;
            end
            else if (!structured)
            begin
                d.verdict = ORDER_EQUAL;
            end
            else if (hv_f < hv_s)
            begin
                d.verdict = ORDER_BEFORE;
            end
            else if (hv_f > hv_s)
            begin
                d.verdict = ORDER_AFTER;
            end
            else if (fl_f < fl_s)
            begin
                d.verdict = ORDER_BEFORE;
            end
            else
            begin
                d.verdict = ORDER_AFTER;
            end
        end
        else if (left_s == '0)
        begin
            d.verdict = ORDER_AFTER;
        end
        else
        begin
            d.done = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [8:0] take_count(input logic [8:0] left, input logic [7:0] len);
        logic [8:0] need;
        need = {1'b0, len} + 9'd1;
        if (left == LEFT_NEG || left < need)
        begin
            return LEFT_NEG;
        end
        return left - need;
    endfunction

    function automatic decision_t end_of_part(
        input logic [7:0]  len_f,
        input logic [7:0]  len_s,
        input decision_t   counts
    );
        decision_t d;
        d.done    = 1'b1;
        d.verdict = ORDER_EQUAL;
        if (len_f > len_s)
        begin
            d.verdict = ORDER_AFTER;
        end
        else if (len_f < len_s)
        begin
            d.verdict = ORDER_BEFORE;
        end
        else
        begin
            d = counts;
        end
        return d;
    endfunction

    assign a       = q_item.first_byte;
    assign b       = q_item.second_byte;
    assign q_ready = !q_item.last || !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;

    assign out_valid = out_valid_reg;
    assign order     = order_reg;
    assign undecided = undecided_reg;

    always_comb
    begin
        header_position_next = header_position_reg;
        first_flags_next     = first_flags_reg;
        second_flags_next    = second_flags_reg;
        first_left_next      = first_left_reg;
        second_left_next     = second_left_reg;
        first_hv_next        = first_hv_reg;
        second_hv_next       = second_hv_reg;
        first_len_next       = first_len_reg;
        second_len_next      = second_len_reg;
        to_compare_next      = to_compare_reg;
        phase_next           = phase_reg;
        ready_next           = ready_reg;
        verdict_next         = verdict_reg;
        dec                  = '0;
        dec_count            = '0;
        out_valid_next       = out_valid_reg && !out_ready;
        order_next           = order_reg;
        undecided_next       = undecided_reg;

        if (pop)
        begin
            if (!ready_reg)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        case (header_position_reg)
                            HDR_FLAGS:
                            begin
                                first_flags_next  = a[6:0];
                                second_flags_next = a[5:0] & '0 | b[5:0];
                            end
                            HDR_COUNTS:
                            begin
                                first_left_next  = {1'b0, a};
                                second_left_next = {1'b0, b};
                                if ((a == '0) != (b == '0))
                                begin
                                    ready_next   = 1'b1;
                                    verdict_next = (a == '0) ? ORDER_BEFORE : ORDER_AFTER;
                                end
                                else if (a == '0 && !first_flags_reg[FLAG_STRUCT_BIT])
                                begin
                                    ready_next   = 1'b1;
                                    verdict_next = ORDER_EQUAL;
                                end
                            end
                            HDR_VALUE_LO:
                            begin
                                first_hv_next  = {6'd0, a};
                                second_hv_next = {6'd0, b};
                            end
                            HDR_VALUE_HI:
                            begin
                                first_hv_next  = {a[5:0], first_hv_reg[7:0]};
                                second_hv_next = {b[5:0], second_hv_reg[7:0]};
                                dec = check_counts(first_left_reg, second_left_reg,
                                                   first_flags_reg[FLAG_STRUCT_BIT],
                                                   {a[5:0], first_hv_reg[7:0]},
                                                   {b[5:0], second_hv_reg[7:0]},
                                                   first_flags_reg[5:0] & FLAG_VALUE_MASK,
                                                   second_flags_reg & FLAG_VALUE_MASK);
                                ready_next   = dec.done;
                                verdict_next = dec.done ? dec.verdict : verdict_reg;
                                if (!dec.done)
                                begin
                                    phase_next = PH_LENGTH;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (header_position_reg < HDR_VALUE_HI)
                        begin
                            header_position_next = header_position_reg + 3'd1;
                        end
                    end
                    PH_LENGTH:
                    begin
                        first_len_next   = a;
                        second_len_next  = b;
                        first_left_next  = take_count(first_left_reg, a);
                        second_left_next = take_count(second_left_reg, b);
                        dec_count        = (a < b) ? a : b;
                        to_compare_next  = dec_count;
                        if (dec_count == '0)
                        begin
                            dec = end_of_part(a, b,
                                      check_counts(first_left_next, second_left_next,
                                                   first_flags_reg[FLAG_STRUCT_BIT],
                                                   first_hv_reg, second_hv_reg,
                                                   first_flags_reg[5:0] & FLAG_VALUE_MASK,
                                                   second_flags_reg & FLAG_VALUE_MASK));
                            ready_next   = dec.done;
                            verdict_next = dec.done ? dec.verdict : verdict_reg;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (a > b)
                        begin
                            ready_next   = 1'b1;
                            verdict_next = ORDER_AFTER;
                        end
                        else if (a < b)
                        begin
                            ready_next   = 1'b1;
                            verdict_next = ORDER_BEFORE;
                        end
                        else
                        begin
                            dec_count       = to_compare_reg - 8'd1;
                            to_compare_next = dec_count;
                            if (dec_count == '0)
                            begin
                                dec = end_of_part(first_len_reg, second_len_reg,
                                          check_counts(first_left_reg, second_left_reg,
                                                       first_flags_reg[FLAG_STRUCT_BIT],
                                                       first_hv_reg, second_hv_reg,
                                                       first_flags_reg[5:0] & FLAG_VALUE_MASK,
                                                       second_flags_reg & FLAG_VALUE_MASK));
                                ready_next   = dec.done;
                                verdict_next = dec.done ? dec.verdict : verdict_reg;
                                if (!dec.done)
                                begin
                                    phase_next = PH_LENGTH;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (q_item.last)
            begin
                out_valid_next = 1'b1;
                order_next     = ready_next ? verdict_next : ORDER_EQUAL;
                undecided_next = !ready_next;

                header_position_next = '0;
                first_flags_next     = '0;
                second_flags_next    = '0;
                first_left_next      = '0;
                second_left_next     = '0;
                first_hv_next        = '0;
                second_hv_next       = '0;
                first_len_next       = '0;
                second_len_next      = '0;
                to_compare_next      = '0;
                phase_next           = PH_HEADER;
                ready_next           = 1'b0;
                verdict_next         = ORDER_EQUAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_position_reg <= '0;
            first_flags_reg     <= '0;
            second_flags_reg    <= '0;
            first_left_reg      <= '0;
            second_left_reg     <= '0;
            first_hv_reg        <= '0;
            second_hv_reg       <= '0;
            first_len_reg       <= '0;
            second_len_reg      <= '0;
            to_compare_reg      <= '0;
            phase_reg           <= PH_HEADER;
            ready_reg           <= 1'b0;
            verdict_reg         <= ORDER_EQUAL;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            header_position_reg <= header_position_next;
            first_flags_reg     <= first_flags_next;
            second_flags_reg    <= second_flags_next;
            first_left_reg      <= first_left_next;
            second_left_reg     <= second_left_next;
            first_hv_reg        <= first_hv_next;
            second_hv_reg       <= second_hv_next;
            first_len_reg       <= first_len_next;
            second_len_reg      <= second_len_next;
            to_compare_reg      <= to_compare_next;
            phase_reg           <= phase_next;
            ready_reg           <= ready_next;
            verdict_reg         <= verdict_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg     <= order_next;
        undecided_reg <= undecided_next;
    end

endmodule
`default_nettype wire

// ===== rtl/structured_sort_key_compare_core.sv =====
// Structured sort key comparator: two keys streamed byte pair by byte pair.
// Usage:
//   Input channel (in_valid/in_ready) carries one byte of each key per transfer,
//   starting at header byte 0; last_pair marks the final pair of a comparison.
//   Output channel (out_valid/out_ready) carries one result per comparison:
//   order (0 equal, 1 first after second, 2 first before second) and
//   undecided (stream ended before a verdict; order is 0 then).
//   Throughput: one pair per cycle while the receiver takes results; nothing iterates.
//   Result path: the pair is written into the two-entry input queue at the
//   transfer edge and the compare engine loads the result register when it
//   takes the pair from the queue.
//   Receiver stall: the queue keeps accepting pairs; only a last pair waits in
//   the queue while a previous result is still pending, so the input stalls
//   once the queue is full.
//   Reset: queue empties, no result is pending, comparison state returns to
//   the header phase; pairs are accepted as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module structured_sort_key_compare_core
    import sskc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] first_key_byte,
    input  wire logic [7:0] second_key_byte,
    input  wire logic       last_pair,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      order,
    output logic            undecided
);

    logic  q_valid;
    logic  q_ready;
    pair_t q_item;

    sskc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_key_byte  (first_key_byte),
        .second_key_byte (second_key_byte),
        .last_pair       (last_pair),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item)
    );

    sskc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .order     (order),
        .undecided (undecided)
    );

    a_undecided_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && undecided |-> order == ORDER_EQUAL)
        else $error("undecided result with nonzero order");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_valid)
        else $error("input stalled with empty queue");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_valid && q_ready && q_item.last))
        else $error("result without a last pair transfer");

    a_non_last_flows: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_item.last |-> q_ready)
        else $error("engine stalled on a non-last pair");

endmodule
`default_nettype wire
